// ----- hdl/dvru_pkg.sv -----
// ----------------------------------------------------------------------------
// dvru_pkg
// Shared types and constants of the distance-vector route update block.
// ----------------------------------------------------------------------------
package dvru_pkg;

  // Fixed field widths of the streams
  localparam int ID_W      = 16;
  localparam int IN_COST_W = 16;
  localparam int ANN_W     = 2;
  localparam int KNOWN_W   = 5;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 8;

  // Announce codes
  localparam logic [ANN_W-1:0] ANN_NONE = 2'd0;
  localparam logic [ANN_W-1:0] ANN_FWD  = 2'd1;
  localparam logic [ANN_W-1:0] ANN_SEND = 2'd2;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_CMP, S_NEW, S_ROW, S_COL, S_ENT, S_ENTW, S_POST,
    S_RA, S_RB, S_RC, S_RD, S_RE, S_OUT
  } state_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_ID_RD, OP_ID_NEXT, OP_FOUND, OP_ADD, OP_DROP,
    OP_ROW_WR, OP_ROW_END, OP_COL_WR, OP_DIAG_WR, OP_ENT_RD, OP_ENT_WR,
    OP_RELAX_INIT, OP_RA, OP_RB, OP_RC, OP_RD, OP_RE, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic i_at_count;  // search index reached the id count
    logic match;       // id read back equals the current key
    logic full;        // no room for another id
    logic i_at_n;      // init index reached the new id's slot
    logic key_dst;     // the current key is the destination id
    logic si_vld;
    logic last;
    logic began_empty;
    logic k_last;
    logic d_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/dvru_ctrl.sv -----
// ----------------------------------------------------------------------------
// dvru_ctrl
// Sequencer: id search, id insertion, entry write and row relaxation.
// ----------------------------------------------------------------------------
module dvru_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  dvru_pkg::dp_status_t st,
  output dvru_pkg::dp_cmd_t    cmd
);
  import dvru_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SRCH;
      S_SRCH: state_nxt = st.i_at_count ? S_NEW : S_CMP;
      S_CMP: begin
        if (!st.match)       state_nxt = S_SRCH;
        else if (st.key_dst) state_nxt = S_ENT;
        else                 state_nxt = S_SRCH;
      end
      S_NEW: begin
        if (!st.full)        state_nxt = S_ROW;
        else if (st.key_dst) state_nxt = S_ENT;
        else                 state_nxt = S_SRCH;
      end
      S_ROW: if (st.i_at_n) state_nxt = S_COL;
      S_COL: begin
        if (st.i_at_n) state_nxt = st.key_dst ? S_ENT : S_SRCH;
      end
      S_ENT:  state_nxt = S_ENTW;
      S_ENTW: state_nxt = S_POST;
      S_POST: begin
        if (!st.last)                      state_nxt = S_IDLE;
        else if (st.began_empty || !st.si_vld) state_nxt = S_OUT;
        else                               state_nxt = S_RA;
      end
      S_RA: state_nxt = S_RB;
      S_RB: state_nxt = S_RC;
      S_RC: state_nxt = st.k_last ? S_RD : S_RA;
      S_RD: state_nxt = S_RE;
      S_RE: state_nxt = st.d_last ? S_OUT : S_RA;
      S_OUT: if (st.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_ACCEPT;
      end
      S_SRCH: if (!st.i_at_count) cmd.op = OP_ID_RD;
      S_CMP:  cmd.op = st.match ? OP_FOUND : OP_ID_NEXT;
      S_NEW:  cmd.op = st.full ? OP_DROP : OP_ADD;
      S_ROW:  cmd.op = st.i_at_n ? OP_ROW_END : OP_ROW_WR;
      S_COL:  cmd.op = st.i_at_n ? OP_DIAG_WR : OP_COL_WR;
      S_ENT:  cmd.op = OP_ENT_RD;
      S_ENTW: cmd.op = OP_ENT_WR;
      S_POST: begin
        if (st.last && !st.began_empty && st.si_vld) cmd.op = OP_RELAX_INIT;
      end
      S_RA:  cmd.op = OP_RA;
      S_RB:  cmd.op = OP_RB;
      S_RC:  cmd.op = OP_RC;
      S_RD:  cmd.op = OP_RD;
      S_RE:  cmd.op = OP_RE;
      S_OUT: if (st.out_free) cmd.op = OP_FINISH;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- hdl/dvru_dp.sv -----
// ----------------------------------------------------------------------------
// dvru_dp
// Datapath: id memory, cost matrix memory, vector flags and result register.
// ----------------------------------------------------------------------------
module dvru_dp #(
  parameter int MAX_ROUTERS = 16,
  parameter int COST_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dvru_pkg::dp_cmd_t                    cmd,
  output dvru_pkg::dp_status_t                 st,
  input  logic [dvru_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dvru_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import dvru_pkg::*;

  localparam int IW = $clog2(MAX_ROUTERS);
  localparam int CW = $clog2(MAX_ROUTERS + 1);
  localparam int MD = MAX_ROUTERS * MAX_ROUTERS;
  localparam int AW = $clog2(MD);
  localparam logic [COST_BITS-1:0] INF = {COST_BITS{1'b1}};

  // Memories
  logic [ID_W-1:0]      id_mem [MAX_ROUTERS];
  logic [COST_BITS-1:0] mat_mem [MD];
  logic [ID_W-1:0]      id_q_r;
  logic [COST_BITS-1:0] mat_q_r;

  // Item and control registers
  logic [ID_W-1:0]        src_r, dst_r;
  logic [COST_BITS-1:0]   cost_r;
  logic                   last_r;
  logic [IW-1:0]          si_r, di_r, n_r, d_r;
  logic                   si_vld_r, di_vld_r, which_r;
  logic [CW-1:0]          cnt_r, i_r;
  logic [MAX_ROUTERS-1:0] seen_r;
  logic                   vchg_r, new_r, ovf_r, open_r, empty_r, rchg_r;
  logic [COST_BITS-1:0]   a_r, min_r;
  logic                   out_vld_r;
  logic [ANN_W-1:0]       ann_r;
  logic                   full_r;
  logic [KNOWN_W-1:0]     known_r;

  logic [ID_W-1:0]        key;
  logic [COST_BITS:0]     sum;
  logic [COST_BITS-1:0]   sum_sat;
  logic [32:0]            cost_ext;
  logic [COST_BITS-1:0]   cost_in;
  logic [MAX_ROUTERS-1:0] all_mask;
  logic                   seen_miss;
  logic [ANN_W-1:0]       ann_nxt;
  logic [7:0]             cnt8;

  function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    maddr = AW'(r) * AW'(MAX_ROUTERS) + AW'(c);
  endfunction

  assign key = which_r ? dst_r : src_r;

  // Clamp the advertised cost to the unreachable code
  assign cost_ext = 33'(in_tdata[47:32]);
  assign cost_in  = (in_tdata[47:32] == {IN_COST_W{1'b1}} || cost_ext > 33'(INF))
                    ? INF : cost_ext[COST_BITS-1:0];

  // Saturating path sum
  assign sum     = {1'b0, a_r} + {1'b0, mat_q_r};
  assign sum_sat = (sum >= {1'b0, INF}) ? INF : sum[COST_BITS-1:0];

  // Ids that did not appear as a destination
  always_comb begin
    for (int j = 0; j < MAX_ROUTERS; j++) begin
      all_mask[j] = (CW'(j) < cnt_r);
    end
  end
  assign seen_miss = ((seen_r & all_mask) != all_mask);

  always_comb begin
    if (empty_r)                                   ann_nxt = ANN_FWD;
    else if (rchg_r)                               ann_nxt = ANN_SEND;
    else if (new_r || ovf_r || vchg_r || seen_miss) ann_nxt = ANN_FWD;
    else                                           ann_nxt = ANN_NONE;
  end

  assign cnt8 = 8'(cnt_r);

  // Status
  assign st.i_at_count  = (i_r == cnt_r);
  assign st.match       = (id_q_r == key);
  assign st.full        = (cnt_r >= CW'(MAX_ROUTERS));
  assign st.i_at_n      = (i_r == CW'(n_r));
  assign st.key_dst     = which_r;
  assign st.si_vld      = si_vld_r;
  assign st.last        = last_r;
  assign st.began_empty = empty_r;
  assign st.k_last      = (i_r + CW'(1) == cnt_r);
  assign st.d_last      = (CW'(d_r) + CW'(1) == cnt_r);
  assign st.out_free    = !out_vld_r || out_tready;

  // Memory ports
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ID_RD: id_q_r <= id_mem[i_r[IW-1:0]];
      OP_ADD:   id_mem[cnt_r[IW-1:0]] <= key;
      OP_ROW_WR: mat_mem[maddr(n_r, i_r[IW-1:0])] <= INF;
      OP_COL_WR: mat_mem[maddr(i_r[IW-1:0], n_r)] <= INF;
      OP_DIAG_WR: mat_mem[maddr(n_r, n_r)] <= '0;
      OP_ENT_RD: mat_q_r <= mat_mem[maddr(si_r, di_r)];
      OP_ENT_WR: begin
        if (si_vld_r && di_vld_r && mat_q_r != cost_r) mat_mem[maddr(si_r, di_r)] <= cost_r;
      end
      OP_RA: mat_q_r <= mat_mem[maddr(si_r, i_r[IW-1:0])];
      OP_RB: mat_q_r <= mat_mem[maddr(i_r[IW-1:0], d_r)];
      OP_RD: mat_q_r <= mat_mem[maddr(si_r, d_r)];
      OP_RE: begin
        if (mat_q_r != min_r) mat_mem[maddr(si_r, d_r)] <= min_r;
      end
      default: ;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        src_r  <= in_tdata[15:0];
        dst_r  <= in_tdata[31:16];
        cost_r <= cost_in;
        last_r <= in_tlast;
      end
      OP_ADD: n_r <= cnt_r[IW-1:0];
      OP_RB:  a_r <= mat_q_r;
      OP_RC: begin
        if (sum_sat < min_r) min_r <= sum_sat;
      end
      OP_RELAX_INIT: begin
        d_r   <= '0;
        min_r <= INF;
      end
      OP_RE: begin
        d_r   <= d_r + IW'(1);
        min_r <= INF;
      end
      OP_FINISH: begin
        ann_r   <= ann_nxt;
        full_r  <= ovf_r;
        known_r <= cnt8[KNOWN_W-1:0];
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      i_r       <= '0;
      which_r   <= 1'b0;
      si_vld_r  <= 1'b0;
      di_vld_r  <= 1'b0;
      si_r      <= '0;
      di_r      <= '0;
      seen_r    <= '0;
      vchg_r    <= 1'b0;
      new_r     <= 1'b0;
      ovf_r     <= 1'b0;
      open_r    <= 1'b0;
      empty_r   <= 1'b0;
      rchg_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready && cmd.op != OP_FINISH) out_vld_r <= 1'b0;
      case (cmd.op)
        OP_ACCEPT: begin
          i_r     <= '0;
          which_r <= 1'b0;
          if (!open_r) begin
            open_r  <= 1'b1;
            empty_r <= (cnt_r == '0);
            seen_r  <= '0;
            vchg_r  <= 1'b0;
            new_r   <= 1'b0;
            ovf_r   <= 1'b0;
            rchg_r  <= 1'b0;
          end
        end
        OP_ID_NEXT: i_r <= i_r + CW'(1);
        OP_FOUND, OP_DROP: begin
          if (which_r) begin
            di_r     <= i_r[IW-1:0];
            di_vld_r <= (cmd.op == OP_FOUND);
          end else begin
            si_r     <= i_r[IW-1:0];
            si_vld_r <= (cmd.op == OP_FOUND);
          end
          if (cmd.op == OP_DROP) ovf_r <= 1'b1;
          which_r <= 1'b1;
          i_r     <= '0;
        end
        OP_ADD:     i_r <= '0;
        OP_ROW_WR:  i_r <= i_r + CW'(1);
        OP_ROW_END: i_r <= '0;
        OP_COL_WR:  i_r <= i_r + CW'(1);
        OP_DIAG_WR: begin
          if (which_r) begin
            di_r     <= n_r;
            di_vld_r <= 1'b1;
          end else begin
            si_r     <= n_r;
            si_vld_r <= 1'b1;
          end
          cnt_r   <= cnt_r + CW'(1);
          new_r   <= 1'b1;
          which_r <= 1'b1;
          i_r     <= '0;
        end
        OP_ENT_RD: if (di_vld_r) seen_r[di_r] <= 1'b1;
        OP_ENT_WR: if (si_vld_r && di_vld_r && mat_q_r != cost_r) vchg_r <= 1'b1;
        OP_RELAX_INIT: begin
          i_r    <= '0;
          rchg_r <= 1'b0;
        end
        OP_RC: i_r <= st.k_last ? '0 : i_r + CW'(1);
        OP_RE: if (mat_q_r != min_r) rchg_r <= 1'b1;
        OP_FINISH: begin
          out_vld_r <= 1'b1;
          open_r    <= 1'b0;
          empty_r   <= 1'b0;
          seen_r    <= '0;
          vchg_r    <= 1'b0;
          new_r     <= 1'b0;
          ovf_r     <= 1'b0;
          rchg_r    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {known_r, full_r, ann_r};

endmodule

// ----- hdl/distance_vector_route_update_top.sv -----
// Sequence: an entry is accepted, each of its two ids is compared with the known ids,
// a new id gets its row and column written (a dropped one sets table_full), and the
// entry is read and written back. A last entry adds the relaxation of its source row,
// unless the vector began on an empty table or lost its source, then loads the result.
// Throughput: one entry at a time; the next entry is taken while a result still waits.
// Reset: synchronous, active low; clears the id count and vector flags, not the memories.
// ----------------------------------------------------------------------------
// distance_vector_route_update_top
// Distance-vector routing table with in-place row relaxation per received vector.
// ----------------------------------------------------------------------------
module distance_vector_route_update_top #(
  parameter int MAX_ROUTERS = 16,
  parameter int COST_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dvru_pkg::IN_DATA_W-1:0]  in_tdata,   // source_id, dest_id, entry_cost
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dvru_pkg::OUT_DATA_W-1:0] out_tdata   // announce, table_full, routers_known
);
  import dvru_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Sequencer
  dvru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Tables and result register
  dvru_dp #(
    .MAX_ROUTERS (MAX_ROUTERS),
    .COST_BITS   (COST_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- tb/sv/route_update_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// route_update_checker
// Watches the entry and announce streams, keeps its own routing table and
// compares each announce item with the predicted one.
// ----------------------------------------------------------------------------
module route_update_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [dvru_pkg::IN_DATA_W-1:0]  in_tdata,   // source_id, dest_id, entry_cost
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [dvru_pkg::OUT_DATA_W-1:0] out_tdata,  // announce, table_full, routers_known
  output int                              err_count,
  output int                              pending
);
  import dvru_pkg::*;

  localparam int NR = 16;
  localparam logic [15:0] COST_INF = 16'hFFFF;

  typedef struct packed {
    logic [4:0]       known;
    logic             full;
    logic [ANN_W-1:0] ann;
  } announce_t;

  logic [15:0] ids [NR];
  logic [15:0] costs [NR][NR];
  int          nids;
  logic [15:0] seen;
  bit          chg, added, dropped, open_vec, was_empty;
  announce_t   announce_q[$];

  function automatic logic [15:0] sum_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 17'(COST_INF)) ? COST_INF : s[15:0];
  endfunction

  function automatic int lookup(logic [15:0] id);
    for (int i = 0; i < nids; i++) if (ids[i] == id) return i;
    return -1;
  endfunction

  // Find an id or append it with an unreachable row and column
  function automatic int insert_id(logic [15:0] id);
    int at;
    at = lookup(id);
    if (at >= 0) return at;
    if (nids >= NR) begin
      dropped = 1;
      return -1;
    end
    ids[nids] = id;
    for (int i = 0; i < nids; i++) begin
      costs[nids][i] = COST_INF;
      costs[i][nids] = COST_INF;
    end
    costs[nids][nids] = '0;
    nids++;
    added = 1;
    return nids - 1;
  endfunction

  // Relax one row in place, in table order
  function automatic bit relax(int s);
    logic [15:0] m, c;
    bit any;
    any = 0;
    for (int d = 0; d < nids; d++) begin
      m = COST_INF;
      for (int k = 0; k < nids; k++) begin
        c = sum_sat(costs[s][k], costs[k][d]);
        if (c < m) m = c;
      end
      if (costs[s][d] != m) begin
        costs[s][d] = m;
        any = 1;
      end
    end
    return any;
  endfunction

  task automatic predict_entry(logic [15:0] src, logic [15:0] dst, logic [15:0] cost,
                               logic lst);
    int si, di;
    logic [15:0] all;
    announce_t r;
    if (!open_vec) begin
      open_vec = 1;
      was_empty = (nids == 0);
      seen = '0; chg = 0; added = 0; dropped = 0;
    end
    si = insert_id(src);
    di = insert_id(dst);
    if (di >= 0) seen[di] = 1'b1;
    if (si >= 0 && di >= 0 && costs[si][di] != cost) begin
      costs[si][di] = cost;
      chg = 1;
    end
    if (lst) begin
      if (was_empty) r.ann = ANN_FWD;
      else begin
        all = (nids >= 16) ? 16'hFFFF : 16'((32'd1 << nids) - 1);
        r.ann = (added || dropped || chg || (seen & all) != all) ? ANN_FWD : ANN_NONE;
        si = lookup(src);
        if (si >= 0 && relax(si)) r.ann = ANN_SEND;
      end
      r.full = dropped;
      r.known = 5'(nids);
      announce_q = {announce_q, r};
      open_vec = 0;
    end
  endtask

  assign pending = announce_q.size();

  // Predict on accepted entries, compare on accepted announces
  always @(posedge clk) begin
    announce_t got, exp_r;
    if (!rst_n) begin
      nids = 0;
      open_vec = 0;
      err_count <= 0;
      announce_q.delete();
    end else begin
      if (in_tvalid && in_tready)
        predict_entry(in_tdata[15:0], in_tdata[31:16], in_tdata[47:32], in_tlast);
      if (out_tvalid && out_tready) begin
        got = out_tdata[7:0];
        if (announce_q.size() == 0) begin
          if (err_count < 10) $display("unexpected announce item %h", got);
          err_count <= err_count + 1;
        end else begin
          exp_r = announce_q.pop_front();
          if (got != exp_r) begin
            if (err_count < 10)
              $display("mismatch: exp ann=%0d full=%0d known=%0d, got ann=%0d full=%0d known=%0d",
                       exp_r.ann, exp_r.full, exp_r.known, got.ann, got.full, got.known);
            err_count <= err_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives distance vectors into the route update block with random idling on
// both streams and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
  import dvru_pkg::*;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    err_count, pending;
  int                    cycles = 0;
  bit                    calm = 0;
  logic [15:0]           pool [24];

  localparam int LIMIT = 8000000;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  distance_vector_route_update_top dut (.*);

  route_update_checker chk (.*);

  // Receiver stalls at random outside the calm stretch
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 20);

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Hold valid across back-to-back items, drop it only while idling
  task automatic send_entry(logic [15:0] src, logic [15:0] dst, logic [15:0] cost,
                            logic lst);
    while (!calm && $urandom_range(99) < 20) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {cost, dst, src};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [15:0] rand_cost();
    case ($urandom_range(9))
      0: return 16'hFFFF;
      1: return 16'hFFFE;
      2: return 16'd0;
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // One vector from src with n entries over the id pool
  task automatic send_vector(logic [15:0] src, int n, int span);
    for (int i = 0; i < n; i++)
      send_entry(src, pool[$urandom_range(span - 1)], rand_cost(), i == n - 1);
  endtask

  initial begin
    int sent;
    for (int i = 0; i < 24; i++) pool[i] = 16'($urandom);
    pool[0] = 16'h0000; pool[1] = 16'hFFFF;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: first vector into empty table, duplicates, extremes, full table
    send_entry(pool[0], pool[1], 16'd5, 0);
    send_entry(pool[0], pool[1], 16'd3, 0);
    send_entry(pool[0], pool[2], 16'hFFFF, 1);
    send_entry(pool[1], pool[0], 16'd1, 0);
    send_entry(pool[1], pool[2], 16'hFFFE, 1);
    send_entry(pool[0], pool[0], 16'd0, 1);
    send_entry(pool[2], pool[1], 16'd7, 1);
    for (int i = 3; i < 20; i++) send_entry(pool[0], pool[i], 16'(i), i == 19);
    send_entry(pool[21], pool[1], 16'd2, 1);
    send_entry(pool[1], pool[2], 16'd1, 1);
    // Random vectors, mostly among known ids, some noise
    sent = 0;
    while (sent < 1000) begin
      int n;
      calm = (sent > 400 && sent < 550);
      n = $urandom_range(1, 12);
      if ($urandom_range(9) == 0)
        send_vector(16'($urandom), n, 24);
      else
        send_vector(pool[$urandom_range(15)], n, 18);
      sent += n;
    end
    in_tvalid <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
